@@ rtl/oss_pkg.sv @@
// shared types and constants for the order statistic sorted set
`default_nettype none
package oss_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned FIELD_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_SELECT = 2'd2,
        OP_RANK   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // update strobes from the control stage to the cell chain
    typedef struct packed {
        logic ins_en;
        logic era_en;
    } upd_t;

endpackage
`default_nettype wire

@@ rtl/oss_cell_array.sv @@
// sorted register chain: per-cell compares, shift on insert and erase, rank select
`default_nettype none
module oss_cell_array #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned CNT_W    = 7
) (
    input  wire logic                               aclk,
    input  wire oss_pkg::upd_t                      upd,
    input  wire logic signed [oss_pkg::DATA_W-1:0]  key,
    input  wire logic [CNT_W-1:0]                   count,
    input  wire logic [CNT_W-1:0]                   rank,
    output logic [CAPACITY-1:0]                     lt_vec,
    output logic                                    any_eq,
    output logic signed [oss_pkg::DATA_W-1:0]       sel_value
);

    logic signed [oss_pkg::DATA_W-1:0] cell_reg  [CAPACITY];
    logic signed [oss_pkg::DATA_W-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0] le_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] sel_hit;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic valid;
        logic prev_le;
        logic signed [oss_pkg::DATA_W-1:0] prev_val;
        logic signed [oss_pkg::DATA_W-1:0] succ_val;

        // per-cell compare against the key, masked to occupied cells
        assign valid     = CNT_W'(i) < count;
        assign lt_vec[i] = valid && (cell_reg[i] < key);
        assign le_vec[i] = valid && (cell_reg[i] <= key);
        assign eq_vec[i] = valid && (cell_reg[i] == key);
        assign sel_hit[i] = (rank == CNT_W'(i + 1));

        // neighbours for the shift, edges of the chain fold back
        if (i == 0) begin : g_first
            assign prev_le  = 1'b1;
            assign prev_val = key;
        end else begin : g_mid
            assign prev_le  = le_vec[i-1];
            assign prev_val = cell_reg[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign succ_val = cell_reg[i];
        end else begin : g_body
            assign succ_val = cell_reg[i+1];
        end

        // insert places the key after equal values, erase closes the gap
        always_comb begin
            cell_next[i] = cell_reg[i];
            if (upd.ins_en) begin
                if (le_vec[i]) begin
                    cell_next[i] = cell_reg[i];
                end else if (prev_le) begin
                    cell_next[i] = key;
                end else begin
                    cell_next[i] = prev_val;
                end
            end else if (upd.era_en) begin
                if (!lt_vec[i]) begin
                    cell_next[i] = succ_val;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (upd.ins_en || upd.era_en) begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    // sorted chain: any equal cell means the first non-smaller cell is equal
    assign any_eq = |eq_vec;

    // one-hot and-or read of the ranked cell
    always_comb begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (sel_hit[i]) begin
                sel_value = sel_value | cell_reg[i];
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/oss_thermo_count.sv @@
// thermometer code to count: locates the last set bit of a leading run of ones
`default_nettype none
module oss_thermo_count #(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned CNT_W    = 7
) (
    input  wire logic [CAPACITY-1:0] thermo,
    output logic [CNT_W-1:0]         count
);

    logic [CAPACITY-1:0] edge_vec;

    // one-hot marker at the top of the run
    for (genvar i = 0; i < CAPACITY; i++) begin : g_edge
        if (i == CAPACITY - 1) begin : g_top
            assign edge_vec[i] = thermo[i];
        end else begin : g_low
            assign edge_vec[i] = thermo[i] && !thermo[i+1];
        end
    end

    // or-encode the marker position plus one
    always_comb begin
        count = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (edge_vec[i]) begin
                count = count | CNT_W'(i + 1);
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/order_statistic_sorted_set.sv @@
// an input beat passes through the input register and then the result register to become a result beat
// throughput: one beat per cycle while the result beat is drained, insert, erase, select and rank query alike
// every cell of the sorted chain compares the key in parallel and combinationally
// the count of stored values and both valid flags clear on reset; cells are not cleared
// cells past the current count never reach a result
`default_nettype none
module order_statistic_sorted_set #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_opcode,
    input  wire logic signed [31:0]  s_key_value,
    input  wire logic [6:0]          s_rank_index,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_selected_value,
    output logic [6:0]               m_rank_result,
    output logic                     m_is_present,
    output logic [1:0]               m_status,
    output logic [6:0]               m_occupancy
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > oss_pkg::FIELD_W) ? CNT_W : oss_pkg::FIELD_W;

    // input register
    logic                              in_valid_reg;
    oss_pkg::opcode_t                  op_reg;
    logic signed [oss_pkg::DATA_W-1:0] key_reg;
    logic [oss_pkg::FIELD_W-1:0]       rank_reg;

    // stored value count
    logic [CNT_W-1:0] count_reg, count_next;

    // result register
    logic                              m_valid_reg;
    logic signed [oss_pkg::DATA_W-1:0] sel_reg, sel_next;
    logic [oss_pkg::FIELD_W-1:0]       rres_reg, rres_next;
    logic                              pres_reg, pres_next;
    oss_pkg::status_t                  status_reg, status_next;
    logic [oss_pkg::FIELD_W-1:0]       occ_reg, occ_next;

    logic                              fire;
    oss_pkg::upd_t                     upd;
    logic [CAPACITY-1:0]               lt_vec;
    logic                              any_eq;
    logic signed [oss_pkg::DATA_W-1:0] sel_value;
    logic [CNT_W-1:0]                  pos_below;
    logic [CNT_W-1:0]                  rank_sel;
    logic                              rank_ok;

    // handshake: work proceeds when the result slot is free or being drained
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    // rank range check at the wider of the two widths
    assign rank_ok  = (rank_reg != '0) && (CMP_W'(rank_reg) <= CMP_W'(count_reg));
    assign rank_sel = rank_ok ? CNT_W'(rank_reg) : '0;

    oss_cell_array #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_cells (
        .aclk      (aclk),
        .upd       (upd),
        .key       (key_reg),
        .count     (count_reg),
        .rank      (rank_sel),
        .lt_vec    (lt_vec),
        .any_eq    (any_eq),
        .sel_value (sel_value)
    );

    oss_thermo_count #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_below (
        .thermo (lt_vec),
        .count  (pos_below)
    );

    // opcode decode and result forming
    always_comb begin
        upd         = '0;
        count_next  = count_reg;
        sel_next    = '0;
        rres_next   = '0;
        pres_next   = 1'b0;
        status_next = oss_pkg::ST_OK;
        case (op_reg)
            oss_pkg::OP_INSERT: begin
                if (CMP_W'(count_reg) >= CMP_W'(CAPACITY)) begin
                    status_next = oss_pkg::ST_FULL;
                end else begin
                    upd.ins_en = fire;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            oss_pkg::OP_ERASE: begin
                if (any_eq) begin
                    upd.era_en = fire;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    status_next = oss_pkg::ST_NOT_FOUND;
                end
            end
            oss_pkg::OP_SELECT: begin
                if (rank_ok) begin
                    sel_next = sel_value;
                end else begin
                    status_next = oss_pkg::ST_RANGE;
                end
            end
            oss_pkg::OP_RANK: begin
                pres_next = any_eq;
                rres_next = oss_pkg::FIELD_W'(pos_below + CNT_W'(any_eq));
            end
            default: begin
                status_next = oss_pkg::ST_OK;
            end
        endcase
        occ_next = oss_pkg::FIELD_W'(count_next);
    end

    // control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_ready && s_valid) begin
            op_reg   <= oss_pkg::opcode_t'(s_opcode);
            key_reg  <= s_key_value;
            rank_reg <= s_rank_index;
        end
        if (fire) begin
            sel_reg    <= sel_next;
            rres_reg   <= rres_next;
            pres_reg   <= pres_next;
            status_reg <= status_next;
            occ_reg    <= occ_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_selected_value = sel_reg;
    assign m_rank_result    = rres_reg;
    assign m_is_present     = pres_reg;
    assign m_status         = status_reg;
    assign m_occupancy      = occ_reg;

endmodule
`default_nettype wire

@@ rtl/oss_checker.sv @@
// port-level checks for the order statistic sorted set, bound to the top level
`default_nettype none
module oss_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_selected_value,
    input wire logic [6:0]  m_rank_result,
    input wire logic        m_is_present,
    input wire logic [1:0]  m_status,
    input wire logic [6:0]  m_occupancy
);

    localparam logic [6:0] CAP7 = 7'(CAPACITY);

    // a stalled result beat holds its place
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result beat dropped while stalled");

    // a full report only when the set is at capacity
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == oss_pkg::ST_FULL) |-> (m_occupancy == CAP7))
        else $error("full reported below capacity");

    // a present key has a rank of at least one
    a_present_rank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_present) |-> (m_rank_result != 7'd0))
        else $error("present key with zero rank");

    // an out-of-range select carries a zero value
    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == oss_pkg::ST_RANGE) |-> (m_selected_value == 32'd0))
        else $error("out-of-range select with nonzero value");

    // successive results move the occupancy by at most one
    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) ##1 (m_valid && $past(aresetn)) |->
        (m_occupancy == $past(m_occupancy) || m_occupancy == $past(m_occupancy) + 7'd1
         || m_occupancy == $past(m_occupancy) - 7'd1))
        else $error("occupancy jumped between results");

endmodule

bind order_statistic_sorted_set oss_checker #(.CAPACITY(CAPACITY)) u_oss_checker (.*);
`default_nettype wire
